// ----- hdl/jrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrc_pkg: shared types and constants for the joystick rotator command block
// Holds the transfer payload structs, configuration layout, register offsets
// and the request and motion codes used by the axis logic.
// ----------------------------------------------------------------------------
package jrc_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int TIME_BITS   = 32;
	localparam int HOLD_BITS   = 16;
	localparam int CODE_BITS   = 2;
	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [1:0] REG_HOLD_OFF  = 2'd0;
	localparam logic [1:0] REG_REVERSE_X = 2'd1;
	localparam logic [1:0] REG_REVERSE_Y = 2'd2;
	localparam logic [1:0] REG_EL_ENABLE = 2'd3;

	localparam logic [HOLD_BITS-1:0] HOLD_OFF_RESET  = 16'd100;
	localparam logic                 REVERSE_RESET   = 1'b0;
	localparam logic                 EL_ENABLE_RESET = 1'b1;

	// Axis stick mode and rotator motion codes: A is ccw or up, B is cw or down.
	localparam logic [CODE_BITS-1:0] MODE_IDLE = 2'd0;
	localparam logic [CODE_BITS-1:0] MODE_A    = 2'd1;
	localparam logic [CODE_BITS-1:0] MODE_B    = 2'd2;

	// Request codes: A and B follow the mode codes.
	localparam logic [CODE_BITS-1:0] REQ_NONE = 2'd0;
	localparam logic [CODE_BITS-1:0] REQ_STOP = 2'd3;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] x_sample;
		logic [SAMPLE_BITS-1:0] y_sample;
		logic [TIME_BITS-1:0]   now_ms;
		logic [CODE_BITS-1:0]   az_motion;
		logic [CODE_BITS-1:0]   el_motion;
	} in_item_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] az_request;
		logic [CODE_BITS-1:0] el_request;
	} out_item_t;

	typedef struct packed {
		logic [HOLD_BITS-1:0] hold_off_ms;
		logic                 reverse_x;
		logic                 reverse_y;
		logic                 elevation_enable;
	} cfg_t;

	typedef struct packed {
		logic                 step;
		logic                 dir_a;
		logic                 dir_b;
		logic [CODE_BITS-1:0] motion;
	} axis_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/joystick_rotator_command.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_rotator_command: joystick to rotator request generator
// Items pass through the input register and then the result register.
// Throughput: one item per cycle unless the output stalls with a result waiting;
// the mode and action time update is made as an item leaves the input register.
// Reset clears the valid flags, rest values, stick modes and action times and
// loads the configuration defaults (hold-off 100 ms, elevation enabled).
// ----------------------------------------------------------------------------
module joystick_rotator_command (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire jrc_pkg::in_item_t             in_data,
	// Output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output jrc_pkg::out_item_t                 out_data,
	// Configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [jrc_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [jrc_pkg::DATA_BITS-1:0] pwdata,
	output logic      [jrc_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready
);
	import jrc_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + 3;

	cfg_t                   cfg;
	in_item_t               item_s1;
	logic                   valid_s1;
	out_item_t              out_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] rest_x_q;
	logic [SAMPLE_BITS-1:0] rest_y_q;

	logic                   out_adv;
	logic                   s1_adv;
	logic                   capture;
	logic                   x_hi, x_lo, y_hi, y_lo;
	axis_ctl_t              az_ctl;
	axis_ctl_t              el_ctl;
	logic [CODE_BITS-1:0]   az_req;
	logic [CODE_BITS-1:0]   el_req;

	// The result register frees up when it is empty or its transfer completes;
	// the input register can then move on, so a new item enters every cycle
	// unless the output side is stalled with a result already waiting.
	assign out_adv  = !out_valid_q || !out_stall;
	assign s1_adv   = valid_s1 && out_adv;
	assign in_stall = valid_s1 && !out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// A zero rest value means the resting position has not been captured yet.
	assign capture = (rest_x_q == '0) || (rest_y_q == '0);

	// Exact 20 percent threshold tests: 5 * |deviation| > rest, taken on the
	// magnitude with the sign given by which side of rest the sample lies.
	function automatic logic beyond(input logic [SAMPLE_BITS-1:0] hi_val,
	                                input logic [SAMPLE_BITS-1:0] lo_val,
	                                input logic [SAMPLE_BITS-1:0] rest);
		logic [PROD_BITS-1:0] diff;
		logic [PROD_BITS-1:0] prod;
		diff = {3'b000, hi_val - lo_val};
		prod = (diff << 2) + diff;
		return (hi_val > lo_val) && (prod > {3'b000, rest});
	endfunction

	assign x_hi = beyond(item_s1.x_sample, rest_x_q, rest_x_q);
	assign x_lo = beyond(rest_x_q, item_s1.x_sample, rest_x_q);
	assign y_hi = beyond(item_s1.y_sample, rest_y_q, rest_y_q);
	assign y_lo = beyond(rest_y_q, item_s1.y_sample, rest_y_q);

	// Azimuth: direction A is ccw (stick high), B is cw. Elevation: A is up
	// (stick high), B is down. The two directions of an axis never hold at
	// once, so the order in which they are checked does not matter.
	always_comb begin
		az_ctl.step   = s1_adv && !capture;
		az_ctl.dir_a  = cfg.reverse_x ? x_lo : x_hi;
		az_ctl.dir_b  = cfg.reverse_x ? x_hi : x_lo;
		az_ctl.motion = item_s1.az_motion;
		el_ctl.step   = s1_adv && !capture && cfg.elevation_enable;
		el_ctl.dir_a  = cfg.reverse_y ? y_lo : y_hi;
		el_ctl.dir_b  = cfg.reverse_y ? y_hi : y_lo;
		el_ctl.motion = item_s1.el_motion;
	end

	jrc_axis u_az_axis (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (az_ctl),
		.now_ms      (item_s1.now_ms),
		.hold_off_ms (cfg.hold_off_ms),
		.request     (az_req)
	);

	jrc_axis u_el_axis (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (el_ctl),
		.now_ms      (item_s1.now_ms),
		.hold_off_ms (cfg.hold_off_ms),
		.request     (el_req)
	);

	// Resting values are taken from the item itself while either is zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_x_q <= '0;
			rest_y_q <= '0;
		end else if (s1_adv && capture) begin
			rest_x_q <= item_s1.x_sample;
			rest_y_q <= item_s1.y_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	// A capture item yields no requests; a disabled elevation axis stays quiet.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.az_request <= capture ? REQ_NONE : az_req;
			out_q.el_request <= (capture || !cfg.elevation_enable) ? REQ_NONE : el_req;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	jrc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

`ifndef SYNTHESIS
	a_capture_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && capture |=>
		(out_q.az_request == REQ_NONE) && (out_q.el_request == REQ_NONE))
		else $error("capture item produced a request");

	a_el_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && !cfg.elevation_enable |=> out_q.el_request == REQ_NONE)
		else $error("elevation request while elevation is disabled");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled result lost or changed");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with room in the pipeline");
`endif

endmodule
`default_nettype wire

// ----- hdl/jrc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrc_cfg_regs: configuration register file
// APB-style write and read access to the hold-off time, the reverse options
// and the elevation enable.
// ----------------------------------------------------------------------------
module jrc_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [jrc_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [jrc_pkg::DATA_BITS-1:0] pwdata,
	output logic      [jrc_pkg::DATA_BITS-1:0] prdata,
	output logic                               pready,
	output jrc_pkg::cfg_t                      cfg
);
	import jrc_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_off_ms      <= HOLD_OFF_RESET;
			cfg_q.reverse_x        <= REVERSE_RESET;
			cfg_q.reverse_y        <= REVERSE_RESET;
			cfg_q.elevation_enable <= EL_ENABLE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HOLD_OFF:  cfg_q.hold_off_ms      <= pwdata[HOLD_BITS-1:0];
				REG_REVERSE_X: cfg_q.reverse_x        <= pwdata[0];
				REG_REVERSE_Y: cfg_q.reverse_y        <= pwdata[0];
				REG_EL_ENABLE: cfg_q.elevation_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HOLD_OFF:  prdata = {{(DATA_BITS-HOLD_BITS){1'b0}}, cfg_q.hold_off_ms};
			REG_REVERSE_X: prdata = {{(DATA_BITS-1){1'b0}}, cfg_q.reverse_x};
			REG_REVERSE_Y: prdata = {{(DATA_BITS-1){1'b0}}, cfg_q.reverse_y};
			REG_EL_ENABLE: prdata = {{(DATA_BITS-1){1'b0}}, cfg_q.elevation_enable};
			default:       prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/jrc_axis.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrc_axis: one rotator axis decision
// Keeps the stick mode and the time of the last action, applies the hold-off
// and turns direction calls into turn or stop requests.
// ----------------------------------------------------------------------------
module jrc_axis (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire jrc_pkg::axis_ctl_t            ctl,
	input  wire logic [jrc_pkg::TIME_BITS-1:0] now_ms,
	input  wire logic [jrc_pkg::HOLD_BITS-1:0] hold_off_ms,
	output logic      [jrc_pkg::CODE_BITS-1:0] request
);
	import jrc_pkg::*;

	logic [CODE_BITS-1:0] mode_q;
	logic [CODE_BITS-1:0] mode_d;
	logic [TIME_BITS-1:0] last_q;
	logic [TIME_BITS-1:0] last_d;
	logic [TIME_BITS-1:0] elapsed;
	logic                 held_off;

	// Elapsed time wraps with the millisecond counter.
	assign elapsed  = now_ms - last_q;
	assign held_off = elapsed > {{(TIME_BITS-HOLD_BITS){1'b0}}, hold_off_ms};

	always_comb begin
		request = REQ_NONE;
		mode_d  = mode_q;
		last_d  = last_q;
		if (held_off) begin
			if (ctl.dir_a) begin
				if (ctl.motion != MODE_A) begin
					request = MODE_A;
				end
				mode_d = MODE_A;
				last_d = now_ms;
			end else if (ctl.dir_b) begin
				if (ctl.motion != MODE_B) begin
					request = MODE_B;
				end
				mode_d = MODE_B;
				last_d = now_ms;
			end else if (mode_q != MODE_IDLE) begin
				if (ctl.motion != MODE_IDLE) begin
					request = REQ_STOP;
					last_d  = now_ms;
				end
				mode_d = MODE_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			last_q <= '0;
		end else if (ctl.step) begin
			mode_q <= mode_d;
			last_q <= last_d;
		end
	end

endmodule
`default_nettype wire
